@@ sv/acss_pkg.sv @@
// shared constants, codes and types of the adc channel scan sequencer
package acss_pkg;

    localparam int MAX_CHANNELS  = 8;
    localparam int NORM_BITS     = 15;
    localparam int TABLE_ENTRIES = 8;
    localparam int STORE_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int MODE_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int RD_W       = 3;
    localparam int SCAN_W     = 4;
    localparam int ID_W       = 5;
    localparam int CFG_BYTE_W = 8;
    localparam int VALUE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ID_TABLE_W = ID_W * TABLE_ENTRIES;
    localparam int CB_TABLE_W = CFG_BYTE_W * TABLE_ENTRIES;

    // item modes
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DONE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_TABLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CFG1_TABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CFG2_TABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF          = 3'd4;

    localparam logic [SCAN_W-1:0]  COUNT_RESET = 4'd1;
    localparam logic [VALUE_W-1:0] VREF_RESET  = 16'd3300;

    // resolution codes from cfg1 bits 3:2
    localparam logic [1:0] RES_8BIT  = 2'd0;
    localparam logic [1:0] RES_12BIT = 2'd1;
    localparam int SHIFT_8BIT  = 7;
    localparam int SHIFT_12BIT = 3;
    localparam int SHIFT_OTHER = 5;

    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
    } acss_cmd_t;

endpackage

@@ sv/acss_ctrl.sv @@
// controller state machine: sequences capture, execute, multiply and output hold
module acss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output acss_pkg::acss_cmd_t cmd
);
    import acss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_EXEC;
                        in_stall_reg <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg     <= ST_OUT;
                    out_valid_reg <= 1'b1;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                        in_stall_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    out_valid_reg <= 1'b0;
                    in_stall_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign in_stall    = in_stall_reg;
    assign out_valid   = out_valid_reg;
    assign cmd.capture = (state_reg == ST_IDLE) && in_valid;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.mul     = (state_reg == ST_MUL);

endmodule

@@ sv/acss_datapath.sv @@
// datapath: config registers, result store, scan state and millivolt multiply
module acss_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  acss_pkg::acss_cmd_t                 cmd,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [acss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [acss_pkg::MODE_W-1:0]         mode,
    input  logic [acss_pkg::SAMPLE_W-1:0]       sample,
    input  logic [acss_pkg::RD_W-1:0]           read_channel,
    output logic                                start_request,
    output logic [acss_pkg::ID_W-1:0]           start_input_id,
    output logic [acss_pkg::CFG_BYTE_W-1:0]     start_cfg1,
    output logic [acss_pkg::CFG_BYTE_W-1:0]     start_cfg2,
    output logic                                busy_res,
    output logic [acss_pkg::VALUE_W-1:0]        normalized_value,
    output logic [acss_pkg::VALUE_W-1:0]        millivolts,
    output logic                                channel_valid
);
    import acss_pkg::*;

    function automatic logic [ID_W-1:0] id_of(input logic [ID_TABLE_W-1:0] tbl,
                                             input logic [SCAN_W-1:0] k);
        logic [ID_W-1:0] r;
        r = '0;
        if (int'(k) < TABLE_ENTRIES)
            r = tbl[ID_W*int'(k[2:0]) +: ID_W];
        return r;
    endfunction

    function automatic logic [CFG_BYTE_W-1:0] byte_of(input logic [CB_TABLE_W-1:0] tbl,
                                                     input logic [SCAN_W-1:0] k);
        logic [CFG_BYTE_W-1:0] r;
        r = '0;
        if (int'(k) < TABLE_ENTRIES)
            r = tbl[CFG_BYTE_W*int'(k[2:0]) +: CFG_BYTE_W];
        return r;
    endfunction

    // configuration
    logic [SCAN_W-1:0]     count_reg;
    logic [ID_TABLE_W-1:0] id_table_reg;
    logic [CB_TABLE_W-1:0] cfg1_table_reg;
    logic [CB_TABLE_W-1:0] cfg2_table_reg;
    logic [VALUE_W-1:0]    vref_reg;

    // captured word
    logic [MODE_W-1:0]   mode_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [RD_W-1:0]     rd_reg;

    // scan state and stores
    logic [SCAN_W-1:0]  scan_reg;
    logic [SCAN_W-1:0]  scan_next;
    logic               pend_reg;
    logic               pend_next;
    logic [VALUE_W-1:0] store_reg [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] flag_reg;

    // result word
    logic                  start_reg;
    logic [ID_W-1:0]       id_reg;
    logic [CFG_BYTE_W-1:0] c1_reg;
    logic [CFG_BYTE_W-1:0] c2_reg;
    logic                  busy_reg;
    logic [VALUE_W-1:0]    norm_reg;
    logic [VALUE_W-1:0]    mv_reg;
    logic                  cv_reg;

    logic                  store_we;
    logic                  start_c;
    logic [SCAN_W-1:0]     start_k;
    logic [SCAN_W-1:0]     scan_inc;
    logic [SCAN_W-1:0]     rd_ext;
    logic [VALUE_W-1:0]    value_c;
    logic [CFG_BYTE_W-1:0] rd_cfg1;
    logic                  cv_c;
    logic [VALUE_W-1:0]    norm_c;
    logic [2*VALUE_W-1:0]  prod;

    assign cfg_ready = 1'b1;
    assign scan_inc  = scan_reg + 4'd1;
    assign rd_ext    = {1'b0, rd_reg};
    assign prod      = norm_reg * vref_reg;

    always_comb
    begin
        scan_next = scan_reg;
        pend_next = pend_reg;
        store_we  = 1'b0;
        start_c   = 1'b0;
        start_k   = '0;
        value_c   = '0;
        rd_cfg1   = '0;
        cv_c      = 1'b0;
        norm_c    = '0;
        case (mode_reg)
            MODE_START:
            begin
                scan_next = '0;
                pend_next = 1'b1;
                start_c   = 1'b1;
            end
            MODE_DONE:
            begin
                // a completion while idle changes nothing
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    store_we  = (int'(scan_reg) < MAX_CHANNELS);
                    scan_next = scan_inc;
                    if (scan_inc != '0 && scan_inc < count_reg
                        && int'(scan_inc) < MAX_CHANNELS)
                    begin
                        pend_next = 1'b1;
                        start_c   = 1'b1;
                        start_k   = scan_inc;
                    end
                end
            end
            MODE_READ:
            begin
                if (int'(rd_ext) < MAX_CHANNELS)
                begin
                    value_c = store_reg[rd_ext[STORE_IDX_W-1:0]];
                    cv_c    = flag_reg[rd_ext[STORE_IDX_W-1:0]];
                    rd_cfg1 = byte_of(cfg1_table_reg, rd_ext);
                end
                case (rd_cfg1[3:2])
                    RES_8BIT:  norm_c = value_c << SHIFT_8BIT;
                    RES_12BIT: norm_c = value_c << SHIFT_12BIT;
                    default:   norm_c = value_c << SHIFT_OTHER;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_RESET;
            id_table_reg   <= '0;
            cfg1_table_reg <= '0;
            cfg2_table_reg <= '0;
            vref_reg       <= VREF_RESET;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
            flag_reg       <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT: count_reg      <= cfg_data[SCAN_W-1:0];
                    CFG_ID_TABLE:      id_table_reg   <= cfg_data[ID_TABLE_W-1:0];
                    CFG_CFG1_TABLE:    cfg1_table_reg <= cfg_data[CB_TABLE_W-1:0];
                    CFG_CFG2_TABLE:    cfg2_table_reg <= cfg_data[CB_TABLE_W-1:0];
                    CFG_VREF:          vref_reg       <= cfg_data[VALUE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.exec)
            begin
                scan_reg <= scan_next;
                pend_reg <= pend_next;
                if (store_we)
                begin
                    store_reg[scan_reg[STORE_IDX_W-1:0]] <= sample_reg;
                    flag_reg[scan_reg[STORE_IDX_W-1:0]]  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            sample_reg <= sample;
            rd_reg     <= read_channel;
        end
        if (cmd.exec)
        begin
            start_reg <= start_c;
            id_reg    <= start_c ? id_of(id_table_reg, start_k) : '0;
            c1_reg    <= start_c ? byte_of(cfg1_table_reg, start_k) : '0;
            c2_reg    <= start_c ? byte_of(cfg2_table_reg, start_k) : '0;
            busy_reg  <= pend_next;
            norm_reg  <= norm_c;
            cv_reg    <= cv_c;
        end
        if (cmd.mul)
            mv_reg <= prod[NORM_BITS +: VALUE_W];
    end

    assign start_request    = start_reg;
    assign start_input_id   = id_reg;
    assign start_cfg1       = c1_reg;
    assign start_cfg2       = c2_reg;
    assign busy_res         = busy_reg;
    assign normalized_value = norm_reg;
    assign millivolts       = mv_reg;
    assign channel_valid    = cv_reg;

endmodule

@@ sv/adc_channel_scan_sequencer_unit.sv @@
// adc channel scan sequencer top level: controller, datapath and checks
// throughput: one word in flight at a time; in_stall stays high from acceptance
// until the result leaves output hold, and out_valid is held there under out_stall;
// the controller walks capture, execute, multiply and output hold in turn
// reset: async active low; clears results, valid flags, scan state, and sets
// channel_count to 1, tables to 0 and vref to 3300 mv
module adc_channel_scan_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [acss_pkg::MODE_W-1:0]         mode,
    input  logic [acss_pkg::SAMPLE_W-1:0]       sample,
    input  logic [acss_pkg::RD_W-1:0]           read_channel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                start_request,
    output logic [acss_pkg::ID_W-1:0]           start_input_id,
    output logic [acss_pkg::CFG_BYTE_W-1:0]     start_cfg1,
    output logic [acss_pkg::CFG_BYTE_W-1:0]     start_cfg2,
    output logic                                busy_res,
    output logic [acss_pkg::VALUE_W-1:0]        normalized_value,
    output logic [acss_pkg::VALUE_W-1:0]        millivolts,
    output logic                                channel_valid,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [acss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import acss_pkg::*;

    acss_cmd_t cmd;

    acss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    acss_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .sample           (sample),
        .read_channel     (read_channel),
        .start_request    (start_request),
        .start_input_id   (start_input_id),
        .start_cfg1       (start_cfg1),
        .start_cfg2       (start_cfg2),
        .busy_res         (busy_res),
        .normalized_value (normalized_value),
        .millivolts       (millivolts),
        .channel_valid    (channel_valid)
    );

    // no new word while a result is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && !in_stall && out_valid))
        else $error("word accepted while result pending");

    // result shows up once the accepted word has passed the execute and multiply states
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##3 out_valid)
        else $error("result latency mismatch");

    // a started conversion always leaves the scan busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_request) |-> busy_res)
        else $error("start without busy");

    // an unconverted channel reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !channel_valid) |-> (normalized_value == '0 && millivolts == '0))
        else $error("nonzero value on invalid channel");

endmodule

@@ tb/adc_channel_scan_sequencer_unit_tb.sv @@
`timescale 1ns / 1ps
// testbench of the adc channel scan sequencer: directed and random words checked against a predictor
module adc_channel_scan_sequencer_unit_tb;
    import acss_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_WORDS   = 200;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic                  start_request;
        logic [ID_W-1:0]       start_input_id;
        logic [CFG_BYTE_W-1:0] start_cfg1;
        logic [CFG_BYTE_W-1:0] start_cfg2;
        logic                  busy_res;
        logic [VALUE_W-1:0]    normalized_value;
        logic [VALUE_W-1:0]    millivolts;
        logic                  channel_valid;
    } readout_t;

    class scan_scoreboard;
        readout_t              expected_readouts[$];
        int                    errors;
        logic [VALUE_W-1:0]    results [MAX_CHANNELS];
        bit                    converted [MAX_CHANNELS];
        logic [SCAN_W-1:0]     scan_pos;
        bit                    pending;
        logic [SCAN_W-1:0]     count_reg;
        logic [ID_TABLE_W-1:0] id_table;
        logic [CB_TABLE_W-1:0] cfg1_table;
        logic [CB_TABLE_W-1:0] cfg2_table;
        logic [VALUE_W-1:0]    vref;

        function void reset_model();
            foreach (results[i])
            begin
                results[i]   = '0;
                converted[i] = 1'b0;
            end
            scan_pos   = '0;
            pending    = 1'b0;
            count_reg  = COUNT_RESET;
            id_table   = '0;
            cfg1_table = '0;
            cfg2_table = '0;
            vref       = VREF_RESET;
            errors     = 0;
            expected_readouts.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CHANNEL_COUNT: count_reg  = data[SCAN_W-1:0];
                CFG_ID_TABLE:      id_table   = data[ID_TABLE_W-1:0];
                CFG_CFG1_TABLE:    cfg1_table = data[CB_TABLE_W-1:0];
                CFG_CFG2_TABLE:    cfg2_table = data[CB_TABLE_W-1:0];
                CFG_VREF:          vref       = data[VALUE_W-1:0];
                default: ;
            endcase
        endfunction

        // channels in one scan, clamped to the table size
        function int active_channels();
            return (int'(count_reg) > MAX_CHANNELS) ? MAX_CHANNELS : int'(count_reg);
        endfunction

        function void launch(int k, inout readout_t r);
            r.start_request  = 1'b1;
            r.start_input_id = id_table[k*ID_W +: ID_W];
            r.start_cfg1     = cfg1_table[k*CFG_BYTE_W +: CFG_BYTE_W];
            r.start_cfg2     = cfg2_table[k*CFG_BYTE_W +: CFG_BYTE_W];
            pending          = 1'b1;
        endfunction

        function void note_word(logic [MODE_W-1:0] m, logic [SAMPLE_W-1:0] s,
                                logic [RD_W-1:0] rd);
            readout_t              r;
            logic [CFG_BYTE_W-1:0] cfg1;
            logic [31:0]           widened;
            logic [31:0]           product;
            int                    shift;
            r = '0;
            case (m)
                MODE_START:
                begin
                    scan_pos = '0;
                    launch(0, r);
                end
                MODE_DONE:
                begin
                    // a completion with nothing outstanding is dropped
                    if (pending)
                    begin
                        pending = 1'b0;
                        if (scan_pos < MAX_CHANNELS)
                        begin
                            results[scan_pos]   = s;
                            converted[scan_pos] = 1'b1;
                        end
                        scan_pos = scan_pos + 1'b1;
                        if (scan_pos != 0 && int'(scan_pos) < active_channels())
                            launch(int'(scan_pos), r);
                    end
                end
                MODE_READ:
                begin
                    cfg1 = cfg1_table[rd*CFG_BYTE_W +: CFG_BYTE_W];
                    case (cfg1[3:2])
                        RES_8BIT:  shift = SHIFT_8BIT;
                        RES_12BIT: shift = SHIFT_12BIT;
                        default:   shift = SHIFT_OTHER;
                    endcase
                    widened            = {16'b0, results[rd]} << shift;
                    r.normalized_value = widened[VALUE_W-1:0];
                    product            = r.normalized_value * vref;
                    r.millivolts       = product[NORM_BITS +: VALUE_W];
                    r.channel_valid    = converted[rd];
                end
                default: ;
            endcase
            r.busy_res = pending;
            expected_readouts.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        endfunction

        function void check_word(readout_t got);
            readout_t want;
            if (expected_readouts.size() == 0)
            begin
                errors++;
                $error("readout word arrived with nothing expected");
                return;
            end
            want = expected_readouts.pop_front();
            compare_field("start_request", want.start_request, got.start_request);
            compare_field("start_input_id", want.start_input_id, got.start_input_id);
            compare_field("start_cfg1", want.start_cfg1, got.start_cfg1);
            compare_field("start_cfg2", want.start_cfg2, got.start_cfg2);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("normalized_value", want.normalized_value, got.normalized_value);
            compare_field("millivolts", want.millivolts, got.millivolts);
            compare_field("channel_valid", want.channel_valid, got.channel_valid);
        endfunction

        function int backlog();
            return expected_readouts.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode;
    logic [SAMPLE_W-1:0]   sample;
    logic [RD_W-1:0]       read_channel;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  start_request;
    logic [ID_W-1:0]       start_input_id;
    logic [CFG_BYTE_W-1:0] start_cfg1;
    logic [CFG_BYTE_W-1:0] start_cfg2;
    logic                  busy_res;
    logic [VALUE_W-1:0]    normalized_value;
    logic [VALUE_W-1:0]    millivolts;
    logic                  channel_valid;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    scan_scoreboard sb;
    int  tx_idle_pct = 10;
    bit  rx_idle_en  = 1'b1;
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  rx_burst    = 0;
    int  quiet_cycles = 0;

    logic [SAMPLE_W-1:0] corner_samples [MAX_CHANNELS] = '{
        16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'h00FF, 16'h0FFF, 16'hAAAA
    };

    adc_channel_scan_sequencer_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .sample           (sample),
        .read_channel     (read_channel),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .start_request    (start_request),
        .start_input_id   (start_input_id),
        .start_cfg1       (start_cfg1),
        .start_cfg2       (start_cfg2),
        .busy_res         (busy_res),
        .normalized_value (normalized_value),
        .millivolts       (millivolts),
        .channel_valid    (channel_valid),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stall: random bursts, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (rx_burst > 0)
        begin
            rx_burst--;
            out_stall <= 1'b1;
        end
        else if (rx_idle_en && $urandom_range(0, 9) == 0)
        begin
            rx_burst = $urandom_range(1, 17) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word('{start_request, start_input_id, start_cfg1, start_cfg2, busy_res,
                            normalized_value, millivolts, channel_valid});
    end

    // watchdog on cycles with no handshake on any channel
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("adc_channel_scan_sequencer_unit_tb: FAIL");
        $finish;
    end

    task automatic send_word(logic [MODE_W-1:0] m, logic [SAMPLE_W-1:0] s,
                             logic [RD_W-1:0] rd);
        @(negedge clk);
        in_valid     <= 1'b1;
        mode         <= m;
        sample       <= s;
        read_channel <= rd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(m, s, rd);
    endtask

    task automatic pause_input(int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // send one word, then maybe leave a gap
    task automatic offer_word(logic [MODE_W-1:0] m, logic [SAMPLE_W-1:0] s,
                              logic [RD_W-1:0] rd);
        send_word(m, s, rd);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
            pause_input($urandom_range(1, 17));
    endtask

    task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain every outstanding readout, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.backlog() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] d;
        int sent;
        int steps;
        int pick;
        sb = new;
        sb.reset_model();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_START;
        sample       = '0;
        read_channel = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_CHANNEL_COUNT;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: empty store, stray completion, unused mode, one-channel scan
        send_word(MODE_READ, 16'hFFFF, 3'd0);
        send_word(MODE_DONE, 16'hFFFF, 3'd7);
        send_word(MODE_UNUSED, 16'h5A5A, 3'd5);
        send_word(MODE_START, 16'h0000, 3'd0);
        send_word(MODE_DONE, 16'hFFFF, 3'd0);
        send_word(MODE_READ, 16'h0000, 3'd0);
        settle();

        // full table, every resolution code, top vref
        load_reg(CFG_CHANNEL_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
        load_reg(CFG_ID_TABLE, 64'hFFFF_FFFF_FFFF_FFFF);
        load_reg(CFG_CFG1_TABLE, 64'hFFFB_F7F3_0C08_0400);
        load_reg(CFG_CFG2_TABLE, 64'h80FF_7F01_A55A_C33C);
        load_reg(CFG_VREF, 64'h1234_5678_9ABC_FFFF);
        send_word(MODE_START, 16'h1111, 3'd1);
        send_word(MODE_UNUSED, 16'hFFFF, 3'd7);
        // restart while busy
        send_word(MODE_START, 16'h2222, 3'd2);
        for (int i = 0; i < MAX_CHANNELS; i++)
            send_word(MODE_DONE, corner_samples[i], RD_W'(i));
        send_word(MODE_DONE, 16'h1234, 3'd3);
        for (int i = 0; i < MAX_CHANNELS; i++)
            send_word(MODE_READ, ~corner_samples[i], RD_W'(i));
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            d = rand_data();
            case (p)
                0:       d[SCAN_W-1:0] = 4'd0;
                1:       d[SCAN_W-1:0] = 4'd15;
                2:       d[SCAN_W-1:0] = 4'd8;
                3:       d[SCAN_W-1:0] = 4'd1;
                default: d[SCAN_W-1:0] = SCAN_W'($urandom_range(0, 15));
            endcase
            load_reg(CFG_CHANNEL_COUNT, d);
            load_reg(CFG_ID_TABLE, (p == 0) ? '1 : (p == 1) ? '0 : rand_data());
            load_reg(CFG_CFG1_TABLE, (p == 1) ? '1 : (p == 2) ? '0 : rand_data());
            load_reg(CFG_CFG2_TABLE, (p == 2) ? '1 : (p == 0) ? '0 : rand_data());
            d = rand_data();
            case (p)
                0: d[VALUE_W-1:0] = '0;
                1: d[VALUE_W-1:0] = '1;
                2: d[VALUE_W-1:0] = 16'd1;
                default: ;
            endcase
            load_reg(CFG_VREF, d);

            if (p == NUM_PHASES - 1)
            begin
                tx_idle_pct = 0;
                rx_idle_en  = 1'b0;
            end
            else
            begin
                tx_idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 5 : 25;
                rx_idle_en  = (p % 4 != 1);
            end
            if (p == 4)
                hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    // well-formed scan with reads sprinkled in, sometimes cut short
                    steps = (sb.active_channels() == 0) ? 1 : sb.active_channels();
                    offer_word(MODE_START, rand_sample(), RD_W'($urandom));
                    sent++;
                    for (int k = 0; k < steps; k++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            offer_word(MODE_READ, rand_sample(), RD_W'($urandom));
                            sent++;
                        end
                        if ($urandom_range(0, 29) == 0)
                            break;
                        offer_word(MODE_DONE, rand_sample(), RD_W'($urandom));
                        sent++;
                    end
                end
                else if (pick < 85)
                begin
                    offer_word(MODE_READ, rand_sample(), RD_W'($urandom));
                    sent++;
                end
                else
                begin
                    offer_word(MODE_W'($urandom_range(0, 3)), rand_sample(), RD_W'($urandom));
                    sent++;
                end
            end
            settle();
        end

        if (sb.errors == 0 && sb.backlog() == 0)
            $display("adc_channel_scan_sequencer_unit_tb: PASS");
        else
            $display("adc_channel_scan_sequencer_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/acss_pkg.sv
sv/acss_ctrl.sv
sv/acss_datapath.sv
sv/adc_channel_scan_sequencer_unit.sv
tb/adc_channel_scan_sequencer_unit_tb.sv
